### sv/gbca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbca_pkg
// Shared types and constants for the gyro bias calibration accumulator.
// ----------------------------------------------------------------------------
package gbca_pkg;

   localparam int AXES         = 3;
   localparam int SAMPLE_BITS  = 16;
   localparam int LANES        = 2 * AXES;
   localparam int SUM_BITS     = SAMPLE_BITS + 17;
   localparam int MEAN_BITS    = 24;
   localparam int FRAC_BITS    = 8;
   localparam int DVD_BITS     = SUM_BITS + FRAC_BITS;
   localparam int DIV_STEPS    = DVD_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

   localparam logic [1:0] REG_TARGET   = 2'd0;
   localparam logic [1:0] REG_INTERVAL = 2'd1;
   localparam logic [1:0] REG_MAX_ABS  = 2'd2;
   localparam logic [1:0] REG_MAX_SPAN = 2'd3;

   localparam logic [1:0] AXIS_NONE = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_COLLECT   = 3'd1,
      PH_READY     = 3'd2,
      PH_FAIL_ABS  = 3'd3,
      PH_FAIL_SPAN = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_STORE,
      ST_OUT
   } fsm_type;

   typedef struct packed {
      logic step;
      logic div_load;
      logic div_step;
      logic div_store;
   } ctl_cmd_type;

   typedef struct packed {
      logic finish;
   } dp_sts_type;

endpackage
`default_nettype wire

### sv/gbca_ctl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbca_ctl
// Sequencer: takes one request, runs the mean divider when a run completes,
// then holds the response until it is taken.
// ----------------------------------------------------------------------------
module gbca_ctl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire gbca_pkg::dp_sts_type sts,
   output gbca_pkg::ctl_cmd_type     cmd
);

   gbca_pkg::fsm_type state_ff, state_in;
   logic [gbca_pkg::DIV_CNT_BITS-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbca_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         gbca_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.step = 1'b1;
               state_in = sts.finish ? gbca_pkg::ST_LOAD : gbca_pkg::ST_OUT;
            end
         end
         gbca_pkg::ST_LOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = gbca_pkg::ST_DIV;
         end
         gbca_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == gbca_pkg::DIV_CNT_BITS'(gbca_pkg::DIV_STEPS - 1)) begin
               state_in = gbca_pkg::ST_STORE;
            end
            cnt_in = cnt_ff + 1'b1;
         end
         gbca_pkg::ST_STORE: begin
            cmd.div_store = 1'b1;
            state_in      = gbca_pkg::ST_OUT;
         end
         gbca_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = gbca_pkg::ST_IDLE;
            end
         end
         default: state_in = gbca_pkg::ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

### sv/gbca_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbca_dp
// Run state, per-axis extremes and sums, limit checks and six restoring
// divider lanes that turn the sums into means.
// ----------------------------------------------------------------------------
module gbca_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire gbca_pkg::ctl_cmd_type cmd,
   output gbca_pkg::dp_sts_type       sts,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_addr,
   input  wire logic [15:0]           csr_wdata,
   input  wire logic                  req_command,
   input  wire logic [31:0]           req_now_ms,
   input  wire logic signed [15:0]    req_gyro_x,
   input  wire logic signed [15:0]    req_gyro_y,
   input  wire logic signed [15:0]    req_gyro_z,
   input  wire logic signed [15:0]    req_accel_x,
   input  wire logic signed [15:0]    req_accel_y,
   input  wire logic signed [15:0]    req_accel_z,
   output logic [2:0]                 rsp_status,
   output logic [1:0]                 rsp_fault_axis,
   output logic                       rsp_means_valid,
   output logic signed [23:0]         rsp_bias_x,
   output logic signed [23:0]         rsp_bias_y,
   output logic signed [23:0]         rsp_bias_z,
   output logic signed [23:0]         rsp_accel_mean_x,
   output logic signed [23:0]         rsp_accel_mean_y,
   output logic signed [23:0]         rsp_accel_mean_z
);

   localparam int SB = gbca_pkg::SAMPLE_BITS;
   localparam int NL = gbca_pkg::LANES;
   localparam int NA = gbca_pkg::AXES;
   localparam int MB = gbca_pkg::MEAN_BITS;
   localparam int DB = gbca_pkg::DVD_BITS;
   localparam int UB = gbca_pkg::SUM_BITS;

   // configuration
   logic [15:0] target_ff, interval_ff, max_abs_ff, max_span_ff;

   // run state
   gbca_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  failed_ff, failed_in;
   logic [15:0] count_ff, count_in;
   logic [31:0] last_ff, last_in;
   logic        has_last_ff, has_last_in;
   logic [15:0] lat_target_ff, lat_target_in;
   logic [15:0] lat_interval_ff, lat_interval_in;
   logic signed [SB-1:0] min_ff [NA];
   logic signed [SB-1:0] min_in [NA];
   logic signed [SB-1:0] max_ff [NA];
   logic signed [SB-1:0] max_in [NA];
   logic signed [UB-1:0] sum_ff [NL];
   logic signed [UB-1:0] sum_in [NL];

   // divider lanes
   logic [DB-1:0] dvd_ff [NL];
   logic [DB-1:0] dvd_in [NL];
   logic [15:0]   rem_ff [NL];
   logic [15:0]   rem_in [NL];
   logic [MB-1:0] quo_ff [NL];
   logic [MB-1:0] quo_in [NL];
   logic          neg_ff [NL];
   logic          neg_in [NL];
   logic [MB-1:0] mean_ff [NL];
   logic [MB-1:0] mean_in [NL];

   logic signed [SB-1:0] smp [NL];
   logic signed [SB-1:0] nmin [NA];
   logic signed [SB-1:0] nmax [NA];
   logic [SB:0]   mag [NA];
   logic [SB:0]   span [NA];
   logic [NA-1:0] abs_hit, span_hit;
   logic [1:0]    abs_axis, span_axis;
   logic [31:0]   gap;
   logic          early;
   logic [15:0]   count_nx;
   logic [UB-1:0] umag;
   logic [16:0]   trial;
   logic          qbit;

   assign smp[0] = req_gyro_x;
   assign smp[1] = req_gyro_y;
   assign smp[2] = req_gyro_z;
   assign smp[3] = req_accel_x;
   assign smp[4] = req_accel_y;
   assign smp[5] = req_accel_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= 16'd1;
         interval_ff <= 16'd0;
         max_abs_ff  <= 16'd32768;
         max_span_ff <= 16'd65535;
      end else if (csr_we) begin
         case (csr_addr)
            gbca_pkg::REG_TARGET:   target_ff   <= csr_wdata;
            gbca_pkg::REG_INTERVAL: interval_ff <= csr_wdata;
            gbca_pkg::REG_MAX_ABS:  max_abs_ff  <= csr_wdata;
            gbca_pkg::REG_MAX_SPAN: max_span_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= gbca_pkg::PH_IDLE;
         failed_ff       <= gbca_pkg::AXIS_NONE;
         count_ff        <= '0;
         has_last_ff     <= 1'b0;
         lat_target_ff   <= 16'd1;
         lat_interval_ff <= 16'd0;
      end else begin
         phase_ff        <= phase_in;
         failed_ff       <= failed_in;
         count_ff        <= count_in;
         has_last_ff     <= has_last_in;
         lat_target_ff   <= lat_target_in;
         lat_interval_ff <= lat_interval_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      for (int a = 0; a < NA; a++) begin
         min_ff[a] <= min_in[a];
         max_ff[a] <= max_in[a];
      end
      for (int l = 0; l < NL; l++) begin
         sum_ff[l]  <= sum_in[l];
         dvd_ff[l]  <= dvd_in[l];
         rem_ff[l]  <= rem_in[l];
         quo_ff[l]  <= quo_in[l];
         neg_ff[l]  <= neg_in[l];
         mean_ff[l] <= mean_in[l];
      end
   end

   // checks on the incoming sample
   always_comb begin
      gap   = req_now_ms - last_ff;
      early = has_last_ff && (gap < {16'd0, lat_interval_ff});
      abs_axis  = gbca_pkg::AXIS_NONE;
      span_axis = gbca_pkg::AXIS_NONE;
      for (int a = 0; a < NA; a++) begin
         mag[a] = smp[a][SB-1] ? ((SB+1)'(0) - {smp[a][SB-1], smp[a]})
                               : {smp[a][SB-1], smp[a]};
         abs_hit[a] = mag[a] > {1'b0, max_abs_ff};
         nmin[a] = ((count_ff == '0) || (smp[a] < min_ff[a])) ? smp[a] : min_ff[a];
         nmax[a] = ((count_ff == '0) || (smp[a] > max_ff[a])) ? smp[a] : max_ff[a];
         span[a] = {nmax[a][SB-1], nmax[a]} - {nmin[a][SB-1], nmin[a]};
         span_hit[a] = span[a] > {1'b0, max_span_ff};
      end
      // lowest failing axis wins
      for (int a = NA - 1; a >= 0; a--) begin
         if (abs_hit[a]) abs_axis = 2'(a);
         if (span_hit[a]) span_axis = 2'(a);
      end
      count_nx = count_ff + 16'd1;
   end

   always_comb begin
      phase_in        = phase_ff;
      failed_in       = failed_ff;
      count_in        = count_ff;
      last_in         = last_ff;
      has_last_in     = has_last_ff;
      lat_target_in   = lat_target_ff;
      lat_interval_in = lat_interval_ff;
      min_in          = min_ff;
      max_in          = max_ff;
      sum_in          = sum_ff;
      sts.finish      = 1'b0;
      if (cmd.step) begin
         if (req_command) begin
            if (target_ff != '0) begin
               phase_in        = gbca_pkg::PH_COLLECT;
               failed_in       = gbca_pkg::AXIS_NONE;
               count_in        = '0;
               has_last_in     = 1'b0;
               lat_target_in   = target_ff;
               lat_interval_in = interval_ff;
               for (int l = 0; l < NL; l++) sum_in[l] = '0;
            end
         end else if (phase_ff == gbca_pkg::PH_COLLECT && !early) begin
            if (abs_hit != '0) begin
               phase_in  = gbca_pkg::PH_FAIL_ABS;
               failed_in = abs_axis;
            end else begin
               min_in = nmin;
               max_in = nmax;
               for (int l = 0; l < NL; l++) begin
                  sum_in[l] = sum_ff[l] + UB'(smp[l]);
               end
               count_in    = count_nx;
               last_in     = req_now_ms;
               has_last_in = 1'b1;
               if (count_nx >= lat_target_ff) begin
                  if (span_hit != '0) begin
                     phase_in  = gbca_pkg::PH_FAIL_SPAN;
                     failed_in = span_axis;
                  end else begin
                     phase_in   = gbca_pkg::PH_READY;
                     failed_in  = gbca_pkg::AXIS_NONE;
                     sts.finish = 1'b1;
                  end
               end
            end
         end
      end
   end

   // restoring division of |sum| * 256 by the sample count, one bit per cycle
   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      mean_in = mean_ff;
      umag    = '0;
      trial   = '0;
      qbit    = 1'b0;
      for (int l = 0; l < NL; l++) begin
         if (cmd.div_load) begin
            neg_in[l] = sum_ff[l][UB-1];
            umag      = sum_ff[l][UB-1] ? (UB'(0) - sum_ff[l]) : sum_ff[l];
            dvd_in[l] = {umag, gbca_pkg::FRAC_BITS'(0)};
            rem_in[l] = '0;
            quo_in[l] = '0;
         end
         if (cmd.div_step) begin
            trial = {rem_ff[l], dvd_ff[l][DB-1]};
            qbit  = trial >= {1'b0, count_ff};
            rem_in[l] = qbit ? 16'(trial - {1'b0, count_ff}) : trial[15:0];
            dvd_in[l] = {dvd_ff[l][DB-2:0], 1'b0};
            quo_in[l] = {quo_ff[l][MB-2:0], qbit};
         end
         if (cmd.div_store) begin
            mean_in[l] = neg_ff[l] ? (MB'(0) - quo_ff[l]) : quo_ff[l];
         end
      end
   end

   always_comb begin
      rsp_status      = phase_ff;
      rsp_fault_axis  = failed_ff;
      rsp_means_valid = phase_ff == gbca_pkg::PH_READY;
      rsp_bias_x       = rsp_means_valid ? mean_ff[0] : '0;
      rsp_bias_y       = rsp_means_valid ? mean_ff[1] : '0;
      rsp_bias_z       = rsp_means_valid ? mean_ff[2] : '0;
      rsp_accel_mean_x = rsp_means_valid ? mean_ff[3] : '0;
      rsp_accel_mean_y = rsp_means_valid ? mean_ff[4] : '0;
      rsp_accel_mean_z = rsp_means_valid ? mean_ff[5] : '0;
   end

endmodule
`default_nettype wire

### sv/gyro_bias_calibration_accumulator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gyro_bias_calibration_accumulator
// Collects gyro and accel samples, checks rate limits and reports the gyro
// bias and accel means of a completed run in 1/256 count units.
// ----------------------------------------------------------------------------
//  channel   handshake           direction  payload
//  req_      req_valid/ready     in         command, now_ms, gyro/accel x,y,z
//  rsp_      rsp_valid/ready     out        status, fault_axis, means
//  csr_      csr_we              in         csr_addr, csr_wdata
//
// One request at a time. A request goes from idle straight to the response state,
// except the one that completes a run: the six means are divided in parallel
// lanes one quotient bit per cycle, 41 steps plus load and store.
// req_ready drops from acceptance until the response transfer.
// Synchronous reset; no clearing pass.
// ----------------------------------------------------------------------------
module gyro_bias_calibration_accumulator (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_command,
   input  wire logic [31:0]        req_now_ms,
   input  wire logic signed [15:0] req_gyro_x,
   input  wire logic signed [15:0] req_gyro_y,
   input  wire logic signed [15:0] req_gyro_z,
   input  wire logic signed [15:0] req_accel_x,
   input  wire logic signed [15:0] req_accel_y,
   input  wire logic signed [15:0] req_accel_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_status,
   output logic [1:0]              rsp_fault_axis,
   output logic                    rsp_means_valid,
   output logic signed [23:0]      rsp_bias_x,
   output logic signed [23:0]      rsp_bias_y,
   output logic signed [23:0]      rsp_bias_z,
   output logic signed [23:0]      rsp_accel_mean_x,
   output logic signed [23:0]      rsp_accel_mean_y,
   output logic signed [23:0]      rsp_accel_mean_z,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_addr,
   input  wire logic [15:0]        csr_wdata
);

   gbca_pkg::ctl_cmd_type cmd;
   gbca_pkg::dp_sts_type  sts;

   gbca_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gbca_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .req_command      (req_command),
      .req_now_ms       (req_now_ms),
      .req_gyro_x       (req_gyro_x),
      .req_gyro_y       (req_gyro_y),
      .req_gyro_z       (req_gyro_z),
      .req_accel_x      (req_accel_x),
      .req_accel_y      (req_accel_y),
      .req_accel_z      (req_accel_z),
      .rsp_status       (rsp_status),
      .rsp_fault_axis   (rsp_fault_axis),
      .rsp_means_valid  (rsp_means_valid),
      .rsp_bias_x       (rsp_bias_x),
      .rsp_bias_y       (rsp_bias_y),
      .rsp_bias_z       (rsp_bias_z),
      .rsp_accel_mean_x (rsp_accel_mean_x),
      .rsp_accel_mean_y (rsp_accel_mean_y),
      .rsp_accel_mean_z (rsp_accel_mean_z)
   );

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response is pending");

   a_means_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_means_valid == (rsp_status == gbca_pkg::PH_READY)))
      else $error("means_valid does not match ready status");

   a_axis_none: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == gbca_pkg::PH_IDLE ||
                     rsp_status == gbca_pkg::PH_COLLECT ||
                     rsp_status == gbca_pkg::PH_READY))
      |-> (rsp_fault_axis == gbca_pkg::AXIS_NONE))
      else $error("fail axis named without a failure");

   a_hidden_means: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_means_valid) |-> (rsp_bias_x == '0 && rsp_accel_mean_z == '0))
      else $error("means shown outside ready");

endmodule
`default_nettype wire
